// ===== hw/rtl/dsrm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dsrm_pkg
// Shared types and constants for the dot-star regex matcher: operation
// codes, special pattern bytes and the per-cell control bundle.
// ---------------------------------------------------------------------------
package dsrm_pkg;

  // default depth of the token store
  localparam int MAX_TOKENS_DEF = 32;

  // special pattern bytes
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h2E;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  // operation codes carried on the input beat
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // control bundle from the top level to one cell
  typedef struct packed {
    logic write;     // store the symbol as a new unstarred token
    logic set_star;  // mark the token in this cell as starred
    logic step;      // advance the active position by one text byte
    logic restart;   // return the active set to the start position
  } cell_ctl_t;

endpackage : dsrm_pkg
`default_nettype wire

// ===== hw/rtl/dsrm_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dsrm_cell
// One pattern position of the matcher chain: holds a token byte, its star
// mark and the active bit of its position, and hands the closure carry and
// the forward match to the next cell.
// ---------------------------------------------------------------------------
module dsrm_cell import dsrm_pkg::*; #(
  parameter bit IS_START = 1'b0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctl_t  ctl,
  input  wire logic [7:0] symbol,
  input  wire logic       in_use,
  input  wire logic       carry_in,
  input  wire logic       fwd_in,
  output logic            closed,
  output logic            carry_out,
  output logic            fwd_out,
  output logic            starred
);

  logic [7:0] token_byte;
  logic       act;
  logic       act_next;
  logic       hit;

  // closure: active here, or reached by skipping starred tokens before
  assign closed    = act | carry_in;
  assign carry_out = closed & starred & in_use;

  // byte compare against the current text beat
  assign hit     = in_use & closed & ((token_byte == ANY_BYTE) || (token_byte == symbol));
  assign fwd_out = hit & ~starred;

  // a starred token loops onto itself, a plain one moves forward
  assign act_next = (hit & starred) | fwd_in;

  // active position bit
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= IS_START;
    end else if (ctl.restart) begin
      act <= IS_START;
    end else if (ctl.step) begin
      act <= act_next;
    end
  end

  // token store entry
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      token_byte <= symbol;
      starred    <= 1'b0;
    end else if (ctl.set_star) begin
      starred <= 1'b1;
    end
  end

endmodule : dsrm_cell
`default_nettype wire

// ===== hw/rtl/dot_star_regex_matcher.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dot_star_regex_matcher
// Anchored whole-string matcher for literal bytes, '.' and '*', built as a
// chain of token cells that track the active pattern positions.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation and symbol. Clear
//   empties the pattern, append adds a pattern byte, text advances the
//   active positions by one byte, end of text produces one result beat.
//   Zero symbols on append and text are dropped.
//   Output channel (out_valid/out_ready) carries matched and
//   pattern_overflow, one beat per end of text.
//   A new beat is taken every cycle unless input stalls (below). The
//   result is in the output register in the cycle after the end beat is
//   taken. The closure over starred tokens ripples combinationally through
//   all MAX_TOKENS cells, like a carry chain, which sets the clock.
//   While a result waits for out_ready, in_ready stays high only if the
//   waiting result is taken in the same cycle; otherwise input stalls.
//   Reset empties the pattern, clears the overflow flag and sets only the
//   start position active; no clearing pass is needed.
// ---------------------------------------------------------------------------
module dot_star_regex_matcher import dsrm_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] symbol,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            matched,
  output logic            pattern_overflow
);

  localparam int CW = $clog2(MAX_TOKENS + 1);

  op_t                 op;
  logic                accept;
  logic                sym_nz;
  logic                do_clear;
  logic                do_append;
  logic                do_text;
  logic                do_end;
  logic                restart;
  logic                prev_starred;
  logic                star_case;
  logic                full;
  logic                hit;

  logic [CW-1:0]       count;
  logic                ovf;
  logic                tail;

  cell_ctl_t           ctl   [MAX_TOKENS];
  logic [MAX_TOKENS:0] carry;
  logic [MAX_TOKENS:0] fwd;
  logic [MAX_TOKENS:0] closed_pos;
  logic [MAX_TOKENS:0] pos_sel;
  logic [MAX_TOKENS-1:0] in_use;
  logic [MAX_TOKENS-1:0] star_sel;
  logic [MAX_TOKENS-1:0] starred_vec;

  // handshake: the output register frees up when its beat is taken
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign op       = op_t'(operation);
  assign sym_nz   = (symbol != NUL_BYTE);

  // operation decode
  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_text   = 1'b0;
    do_end    = 1'b0;
    unique case (op)
      OP_CLEAR:  do_clear  = accept;
      OP_APPEND: do_append = accept & sym_nz;
      OP_TEXT:   do_text   = accept & sym_nz;
      OP_END:    do_end    = accept;
      default:   do_end    = 1'b0;
    endcase
  end

  assign restart = do_clear | do_append | do_end;

  // per-position selects derived from the token count
  always_comb begin
    for (int i = 0; i <= MAX_TOKENS; i++) begin
      pos_sel[i] = (count == CW'(i));
    end
    for (int i = 0; i < MAX_TOKENS; i++) begin
      in_use[i]   = (CW'(i) < count);
      star_sel[i] = (count == CW'(i + 1));
    end
  end

  // star handling: stars the last token unless it is already starred
  assign prev_starred = |(star_sel & starred_vec);
  assign star_case    = (symbol == STAR_BYTE) && (count != '0) && !prev_starred;
  assign full         = (count == CW'(MAX_TOKENS));

  // control bundles for the cells
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      ctl[i].write    = do_append & ~star_case & pos_sel[i];
      ctl[i].set_star = do_append & star_case & star_sel[i];
      ctl[i].step     = do_text;
      ctl[i].restart  = restart;
    end
  end

  // cell chain
  assign carry[0] = 1'b0;
  assign fwd[0]   = 1'b0;

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
    dsrm_cell #(
      .IS_START (g == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[g]),
      .symbol    (symbol),
      .in_use    (in_use[g]),
      .carry_in  (carry[g]),
      .fwd_in    (fwd[g]),
      .closed    (closed_pos[g]),
      .carry_out (carry[g+1]),
      .fwd_out   (fwd[g+1]),
      .starred   (starred_vec[g])
    );
  end

  // final position past the last cell
  assign closed_pos[MAX_TOKENS] = tail | carry[MAX_TOKENS];
  assign hit = |(closed_pos & pos_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 1'b0;
    end else if (restart) begin
      tail <= 1'b0;
    end else if (do_text) begin
      tail <= fwd[MAX_TOKENS];
    end
  end

  // token count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (do_clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (do_append && !star_case) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      matched          <= hit & ~ovf;
      pattern_overflow <= ovf;
    end
  end

`ifndef SYNTHESIS
  // an overflowed pattern never reports a match
  a_no_match_on_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && pattern_overflow))
    else $error("match reported with overflowed pattern");

  // the token count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TOKENS))
    else $error("token count beyond store depth");

  // an end beat always loads a result beat
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    do_end |=> out_valid)
    else $error("end of text lost its result");

  // clear empties the pattern and the overflow flag
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (count == '0) && !ovf && !tail)
    else $error("clear left pattern state behind");
`endif

endmodule : dot_star_regex_matcher
`default_nettype wire

// ===== verif/tb_dot_star_regex_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dot_star_regex_matcher
// Self-checking bench for the anchored dot-star matcher. A short stimulus
// table covers empty patterns, leading and doubled stars, '.', zero bytes and
// restarts. Random pattern/text jobs follow, most of them texts derived from
// the pattern so that matches are common, plus long patterns that overflow
// the token store and a little noise. Results are checked against an
// in-bench NFA predictor under random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module tb_dot_star_regex_matcher;
  import dsrm_pkg::*;

  localparam int DEPTH        = MAX_TOKENS_DEF;
  localparam int RAND_BEATS   = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_ROWS     = 26;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] sym;
    logic       typed;      // expected result written in the row
    logic       t_matched;
    logic       t_overflow;
  } stim_row_t;

  // directed stimulus, typed results only where obvious
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{OP_END,    8'h00, 1'b1, 1'b1, 1'b0},  // empty pattern, empty text
    '{OP_TEXT,   8'h80, 1'b0, 1'b0, 1'b0},
    '{OP_END,    8'hFF, 1'b1, 1'b0, 1'b0},  // leftover text never matches
    '{OP_APPEND, STAR_BYTE, 1'b0, 1'b0, 1'b0},  // leading star is a literal
    '{OP_APPEND, STAR_BYTE, 1'b0, 1'b0, 1'b0},  // stars the literal star
    '{OP_APPEND, STAR_BYTE, 1'b0, 1'b0, 1'b0},  // already starred, literal
    '{OP_TEXT,   STAR_BYTE, 1'b0, 1'b0, 1'b0},
    '{OP_TEXT,   STAR_BYTE, 1'b0, 1'b0, 1'b0},
    '{OP_END,    8'h00, 1'b0, 1'b0, 1'b0},
    '{OP_APPEND, NUL_BYTE, 1'b0, 1'b0, 1'b0},   // zero pattern byte dropped
    '{OP_TEXT,   NUL_BYTE, 1'b0, 1'b0, 1'b0},   // zero text byte dropped
    '{OP_END,    8'h00, 1'b0, 1'b0, 1'b0},
    '{OP_CLEAR,  8'hFF, 1'b0, 1'b0, 1'b0},
    '{OP_APPEND, ANY_BYTE, 1'b0, 1'b0, 1'b0},
    '{OP_APPEND, STAR_BYTE, 1'b0, 1'b0, 1'b0},
    '{OP_APPEND, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{OP_TEXT,   8'h01, 1'b0, 1'b0, 1'b0},
    '{OP_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0},
    '{OP_END,    8'h00, 1'b0, 1'b0, 1'b0},
    '{OP_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0},
    '{OP_APPEND, 8'h01, 1'b0, 1'b0, 1'b0},  // append restarts the text
    '{OP_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0},
    '{OP_TEXT,   8'h01, 1'b0, 1'b0, 1'b0},
    '{OP_END,    8'h55, 1'b0, 1'b0, 1'b0},
    '{OP_CLEAR,  8'h00, 1'b0, 1'b0, 1'b0},
    '{OP_END,    8'hAA, 1'b1, 1'b1, 1'b0}   // cleared pattern, empty text
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] operation = OP_CLEAR;
  logic [7:0] symbol    = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       matched;
  logic       pattern_overflow;

  // predictor state: token store, active positions, overflow
  logic [7:0]   tok_byte [DEPTH];
  logic         tok_star [DEPTH];
  int           tok_len   = 0;
  logic [DEPTH:0] live_pos = 1;
  logic         store_ovf = 1'b0;

  verdict_t verdict_q [$];

  int errors       = 0;
  int cycle_cnt    = 0;
  int beats_sent   = 0;
  int results_seen = 0;
  int hit_count    = 0;
  int ovf_count    = 0;
  int burst_left   = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int rdy_mode     = 0;
  int rdy_phase    = 0;

  dot_star_regex_matcher u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .symbol           (symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // epsilon moves over starred tokens
  function automatic logic [DEPTH:0] star_closure(logic [DEPTH:0] s);
    for (int i = 0; i < tok_len; i++) begin
      if (s[i] && tok_star[i]) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  // advance the predictor by one beat; has_res marks an end of text
  task automatic predict_match(op_t op, logic [7:0] sym, output logic has_res,
                               output verdict_t v);
    logic [DEPTH:0] cur;
    logic [DEPTH:0] nxt;
    has_res = 1'b0;
    v = '0;
    case (op)
      OP_CLEAR: begin
        tok_len = 0;
        store_ovf = 1'b0;
        live_pos = 1;
      end
      OP_APPEND: begin
        if (sym != NUL_BYTE) begin
          live_pos = 1;
          if (sym == STAR_BYTE && tok_len > 0 && !tok_star[tok_len-1]) begin
            tok_star[tok_len-1] = 1'b1;
          end else if (tok_len >= DEPTH) begin
            store_ovf = 1'b1;
          end else begin
            tok_byte[tok_len] = sym;
            tok_star[tok_len] = 1'b0;
            tok_len++;
          end
        end
      end
      OP_TEXT: begin
        if (sym != NUL_BYTE) begin
          cur = star_closure(live_pos);
          nxt = '0;
          for (int i = 0; i < tok_len; i++) begin
            if (cur[i] && (tok_byte[i] == ANY_BYTE || tok_byte[i] == sym)) begin
              if (tok_star[i]) nxt[i] = 1'b1;
              else nxt[i+1] = 1'b1;
            end
          end
          live_pos = nxt;
        end
      end
      default: begin
        cur = star_closure(live_pos);
        has_res = 1'b1;
        v.matched = store_ovf ? 1'b0 : cur[tok_len];
        v.overflow = store_ovf;
        live_pos = 1;
      end
    endcase
  endtask

  // one input beat, with sender bursts and gaps
  task automatic drive_beat(op_t op, logic [7:0] sym, logic typed = 1'b0,
                            verdict_t typed_v = '0);
    logic has_res;
    verdict_t v;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    symbol    <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_match(op, sym, has_res, v);
    if (has_res) verdict_q.push_back(typed ? typed_v : v);
    beats_sent++;
    op_count[op]++;
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'h61;
    if (r < 40) return 8'h62;
    if (r < 48) return 8'h63;
    if (r < 63) return ANY_BYTE;
    if (r < 88) return STAR_BYTE;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61;
    if (r < 55) return 8'h62;
    if (r < 65) return 8'h63;
    if (r < 75) return STAR_BYTE;
    return 8'($urandom_range(1, 255));
  endfunction

  // walk the pattern and emit a text it should accept
  task automatic derive_text(const ref logic [7:0] pat[$], ref logic [7:0] txt[$]);
    int i;
    int reps;
    logic starred;
    i = 0;
    txt.delete();
    while (i < pat.size()) begin
      starred = (i + 1 < pat.size()) && (pat[i+1] == STAR_BYTE);
      reps = starred ? $urandom_range(0, 2) : 1;
      repeat (reps) begin
        txt.push_back(pat[i] == ANY_BYTE ? 8'($urandom_range(1, 255)) : pat[i]);
      end
      i += starred ? 2 : 1;
    end
  endtask

  // one random job: noise, or pattern followed by a few texts
  task automatic run_job();
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int plen;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) begin
        drive_beat(op_t'($urandom_range(0, 3)),
                   ($urandom_range(0, 7) == 0) ? NUL_BYTE : 8'($urandom));
      end
    end else begin
      if ($urandom_range(0, 9) < 7) drive_beat(OP_CLEAR, 8'($urandom));
      plen = ($urandom_range(0, 99) < 12) ? $urandom_range(28, 40)
                                          : $urandom_range(0, 8);
      repeat (plen) pat.push_back(pick_pattern_byte());
      foreach (pat[k]) begin
        if ($urandom_range(0, 39) == 0) drive_beat(OP_APPEND, NUL_BYTE);
        drive_beat(OP_APPEND, pat[k]);
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) < 6) begin
          derive_text(pat, txt);
        end else begin
          txt.delete();
          repeat ($urandom_range(0, 8)) txt.push_back(pick_text_byte());
        end
        foreach (txt[k]) begin
          if ($urandom_range(0, 29) == 0) drive_beat(OP_TEXT, NUL_BYTE);
          // stray pattern byte in mid-text restarts the text
          if ($urandom_range(0, 49) == 0) drive_beat(OP_APPEND, pick_pattern_byte());
          drive_beat(OP_TEXT, txt[k]);
        end
        drive_beat(OP_END, 8'($urandom));
      end
    end
  endtask

  // receiver stall pattern: modes held for random stretches
  always @(posedge clk) begin
    if (rdy_phase == 0) begin
      rdy_mode  <= $urandom_range(0, 3);
      rdy_phase <= $urandom_range(20, 120);
    end else begin
      rdy_phase <= rdy_phase - 1;
    end
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycle_cnt % 5) < 2);
    endcase
  end

  // result beat checker
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = verdict_q.pop_front();
        if (matched !== want.matched)
          report_mismatch($sformatf("matched got %b want %b", matched, want.matched));
        if (pattern_overflow !== want.overflow)
          report_mismatch($sformatf("pattern_overflow got %b want %b",
                                    pattern_overflow, want.overflow));
        if (want.matched) hit_count++;
        if (want.overflow) ovf_count++;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int guard;
    verdict_t leftover;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (STIM_ROWS[r]) begin
      drive_beat(STIM_ROWS[r].op, STIM_ROWS[r].sym, STIM_ROWS[r].typed,
                 '{STIM_ROWS[r].t_matched, STIM_ROWS[r].t_overflow});
    end

    // random jobs
    while (beats_sent < NUM_ROWS + RAND_BEATS) run_job();
    in_valid <= 1'b0;

    // drain outstanding results
    guard = 0;
    while (verdict_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (verdict_q.size() != 0) begin
      leftover = verdict_q.pop_front();
      report_mismatch($sformatf("missing result, expected matched %b overflow %b",
                                leftover.matched, leftover.overflow));
    end

    $display("beats %0d (clear %0d append %0d text %0d end %0d), results %0d",
             beats_sent, op_count[OP_CLEAR], op_count[OP_APPEND],
             op_count[OP_TEXT], op_count[OP_END], results_seen);
    $display("matches %0d, overflowed patterns %0d, mismatches %0d",
             hit_count, ovf_count, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
